// ===== rtl/iau_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer arithmetic unit package
// Shared payload types, operation codes and queue constants.
// ----------------------------------------------------------------------------
package iau_pkg;

    localparam int FIELD_W     = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = 1;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [FIELD_W-1:0]  operand_a;
        logic [FIELD_W-1:0]  operand_b;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  value;
        logic [FIELD_W-1:0]  remainder;
    } out_item_t;

    typedef struct packed {
        logic is_add;
        logic is_sub;
        logic is_mul;
        logic is_div;
    } op_sel_t;

    typedef struct packed {
        op_sel_t             sel;
        logic [FIELD_W-1:0]  operand_a;
        logic [FIELD_W-1:0]  operand_b;
    } op_item_t;

endpackage

// ===== rtl/iau_front.sv =====
// ----------------------------------------------------------------------------
// Integer arithmetic unit front end
// Accepts beats into a short queue and decodes the operation kind.
// ----------------------------------------------------------------------------
module iau_front
    import iau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  request,
    input  logic      push,
    output logic      full,
    output op_item_t  head,
    output logic      head_valid,
    input  logic      take
);

    in_item_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    logic              do_push;
    logic              do_pop;
    in_item_t          raw;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = take && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= request;
        end
    end

    always_comb
    begin
        raw            = mem_reg[rd_ptr_reg];
        head.operand_a = raw.operand_a;
        head.operand_b = raw.operand_b;
        head.sel       = '0;
        unique case (raw.kind)
            KIND_ADD: head.sel.is_add = 1'b1;
            KIND_SUB: head.sel.is_sub = 1'b1;
            KIND_MUL: head.sel.is_mul = 1'b1;
            KIND_DIV: head.sel.is_div = 1'b1;
            default:  head.sel.is_div = 1'b1;
        endcase
    end

endmodule

// ===== rtl/iau_back.sv =====
// ----------------------------------------------------------------------------
// Integer arithmetic unit back end
// Product stage, one restoring divide step per stage, and a result register.
// ----------------------------------------------------------------------------
module iau_back
    import iau_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_item_t   head,
    input  logic       head_valid,
    output logic       take,
    output out_item_t  response,
    output logic       empty,
    input  logic       pop
);

    localparam int W = DATA_WIDTH;
    localparam int H = (W + 1) / 2;

    logic adv;

    logic               s0_valid_reg;
    op_sel_t            s0_sel_reg;
    logic [W-1:0]       s0_a_reg;
    logic [W-1:0]       s0_b_reg;
    logic [W-1:0]       s0_arith_reg;
    logic [2*H-1:0]     s0_pll_reg;
    logic [W-1:0]       s0_plh_reg;
    logic [W-1:0]       s0_phl_reg;

    logic [W-1:0]       a_in;
    logic [W-1:0]       b_in;
    logic [W-1:0]       mul_sum;

    logic               st_valid_reg [W];
    logic               st_div_reg   [W];
    logic [W-1:0]       st_r_reg     [W];
    logic [W-1:0]       st_aq_reg    [W];
    logic [W-1:0]       st_b_reg     [W];
    logic [W-1:0]       st_res_reg   [W];

    logic [W-1:0]       r_in   [W];
    logic [W-1:0]       aq_in  [W];
    logic [W-1:0]       r_out  [W];
    logic [W-1:0]       aq_out [W];

    logic               out_valid_reg;
    out_item_t          out_reg;

    assign adv      = !out_valid_reg || pop;
    assign take     = adv;
    assign empty    = !out_valid_reg;
    assign response = out_reg;

    assign a_in = head.operand_a[W-1:0];
    assign b_in = head.operand_b[W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_sel_reg   <= head.sel;
            s0_a_reg     <= a_in;
            s0_b_reg     <= b_in;
            s0_arith_reg <= head.sel.is_sub ? (a_in - b_in) : (a_in + b_in);
            s0_pll_reg   <= a_in[H-1:0] * b_in[H-1:0];
            s0_plh_reg   <= W'(a_in[H-1:0] * b_in[W-1:H]);
            s0_phl_reg   <= W'(a_in[W-1:H] * b_in[H-1:0]);
        end
    end

    assign mul_sum = W'(s0_pll_reg) + W'((s0_plh_reg + s0_phl_reg) << H);

    always_comb
    begin
        r_in[0]  = '0;
        aq_in[0] = s0_a_reg;
        for (int j = 1; j < W; j++)
        begin
            r_in[j]  = st_r_reg[j-1];
            aq_in[j] = st_aq_reg[j-1];
        end
    end

    for (genvar j = 0; j < W; j++)
    begin : g_step
        logic           over;
        logic [W-1:0]   rs;
        logic [W+1:0]   diff;
        logic           ge;
        logic [W-1:0]   b_cur;

        assign b_cur = (j == 0) ? s0_b_reg : st_b_reg[(j == 0) ? 0 : j-1];
        assign over  = r_in[j][W-1];
        assign rs    = {r_in[j][W-2:0], aq_in[j][W-1]};
        assign diff  = {1'b0, over, rs} - {2'b00, b_cur};
        assign ge    = !diff[W+1];
        assign r_out[j]  = ge ? diff[W-1:0] : rs;
        assign aq_out[j] = {aq_in[j][W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < W; j++)
            begin
                st_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s0_valid_reg    <= head_valid;
            st_valid_reg[0] <= s0_valid_reg;
            for (int j = 1; j < W; j++)
            begin
                st_valid_reg[j] <= st_valid_reg[j-1];
            end
            out_valid_reg <= st_valid_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_div_reg[0] <= s0_sel_reg.is_div;
            st_b_reg[0]   <= s0_b_reg;
            st_res_reg[0] <= s0_sel_reg.is_mul ? mul_sum : s0_arith_reg;
            for (int j = 1; j < W; j++)
            begin
                st_div_reg[j] <= st_div_reg[j-1];
                st_b_reg[j]   <= st_b_reg[j-1];
                st_res_reg[j] <= st_res_reg[j-1];
            end
            for (int j = 0; j < W; j++)
            begin
                st_r_reg[j]  <= r_out[j];
                st_aq_reg[j] <= aq_out[j];
            end
            if (st_div_reg[W-1])
            begin
                out_reg.value     <= FIELD_W'(st_aq_reg[W-1]);
                out_reg.remainder <= FIELD_W'(st_r_reg[W-1]);
            end
            else
            begin
                out_reg.value     <= FIELD_W'(st_res_reg[W-1]);
                out_reg.remainder <= '0;
            end
        end
    end

endmodule

// ===== rtl/uint64_add_sub_mul_div_unit.sv =====
// ----------------------------------------------------------------------------
// Unsigned add, subtract, multiply and divide unit
// Queue-style front end feeding a fully pipelined arithmetic back end.
// ----------------------------------------------------------------------------
// The unit takes one beat per cycle while the back end is not held, and returns one
// result beat per request, in order. Every operation passes the same pipeline
// from the front queue to the result register: one product stage, one
// restoring divide step per stage, and the output register. The whole back
// end holds while a result waits, and the two-entry front queue absorbs the
// beats that arrive meanwhile.
module uint64_add_sub_mul_div_unit
    import iau_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   request,
    input  logic       push,
    output logic       full,
    output out_item_t  response,
    output logic       empty,
    input  logic       pop
);

    op_item_t head;
    logic     head_valid;
    logic     take;

    iau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push       (push),
        .full       (full),
        .head       (head),
        .head_valid (head_valid),
        .take       (take)
    );

    iau_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .take       (take),
        .response   (response),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef NO_ASSERTIONS
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        full && !empty && !pop |=> full)
        else $error("queue drained while the back end was stalled");

    a_idle_no_full: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && empty |=> !full)
        else $error("queue filled although the back end was advancing");
`endif

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Arithmetic unit testbench
// Drives add, subtract, multiply and divide beats through the queue ports and
// checks every result beat in order against an internal arithmetic predictor.
// ----------------------------------------------------------------------------
module testbench;
    import iau_pkg::*;

    localparam int LATENCY = 70;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 200;

    logic       clk;
    logic       rst_n;
    in_item_t   request;
    logic       push;
    logic       full;
    out_item_t  response;
    logic       empty;
    logic       pop;

    out_item_t  expected_results[$];
    int         error_count;
    longint     cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    logic       hold_off_req;
    logic       hold_off_seen;
    int         hold_off_cycles;

    uint64_add_sub_mul_div_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .push     (push),
        .full     (full),
        .response (response),
        .empty    (empty),
        .pop      (pop)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic out_item_t compute_result(in_item_t item);
        out_item_t  res;
        logic [63:0] a;
        logic [63:0] b;
        logic [64:0] rem;
        logic [63:0] quo;
        a = item.operand_a;
        b = item.operand_b;
        res.value = '0;
        res.remainder = '0;
        case (item.kind)
            KIND_ADD: res.value = a + b;
            KIND_SUB: res.value = a - b;
            KIND_MUL: res.value = a * b;
            default:
            begin
                rem = '0;
                quo = '0;
                for (int i = 63; i >= 0; i--)
                begin
                    rem = {rem[63:0], a[i]};
                    quo = quo << 1;
                    if (rem >= {1'b0, b})
                    begin
                        rem = rem - {1'b0, b};
                        quo[0] = 1'b1;
                    end
                end
                res.value = quo;
                res.remainder = rem[63:0];
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = v >> $urandom_range(1, 63);
            3: v = 64'd1 << $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop             <= 1'b0;
            hold_off_seen   <= 1'b0;
            hold_off_cycles <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Result beat with no expectation: value %h", response.value);
                    error_count++;
                end
                else
                begin
                    if (response.value !== expected_results[0].value)
                    begin
                        $error("value: expected %h, actual %h",
                               expected_results[0].value, response.value);
                        error_count++;
                    end
                    if (response.remainder !== expected_results[0].remainder)
                    begin
                        $error("remainder: expected %h, actual %h",
                               expected_results[0].remainder, response.remainder);
                        error_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (hold_off_req && !hold_off_seen)
            begin
                hold_off_seen   <= 1'b1;
                hold_off_cycles <= HOLD_OFF_CYCLES;
                pop             <= 1'b0;
            end
            else if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_beat(kind_t kind, logic [63:0] a, logic [63:0] b);
        in_item_t item;
        item.kind = kind;
        item.operand_a = a;
        item.operand_b = b;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        request <= item;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        expected_results.push_back(compute_result(item));
    endtask

    task automatic test_directed();
        logic [63:0] edges[5];
        edges = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h0000_0000_FFFF_FFFF};
        for (int k = 0; k < 4; k++)
        begin
            send_beat(kind_t'(k), edges[2], edges[2]);
            send_beat(kind_t'(k), edges[0], edges[1]);
            send_beat(kind_t'(k), edges[3], edges[4]);
        end
        send_beat(KIND_DIV, 64'd12345, 64'd0);
        send_beat(KIND_DIV, edges[2], 64'd0);
        send_beat(KIND_DIV, 64'd7, 64'd9);
        send_beat(KIND_DIV, edges[2], edges[3]);
        send_beat(KIND_SUB, 64'd0, edges[2]);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_beat(kind_t'($urandom_range(0, 3)), random_operand(), random_operand());
        end
    endtask

    task automatic test_back_pressure();
        hold_off_req = 1'b1;
        test_random(100);
    endtask

    task automatic drain();
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        request = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off_req = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 20;
        recv_idle_pct = 68;
        test_random(260);
        send_idle_pct = 68;
        recv_idle_pct = 20;
        test_random(260);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_pressure();
        test_random(180);
        push <= 1'b0;
        drain();
        repeat (LATENCY) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
